### rtl/core/ure_pkg.sv
// Shared types, codes and the sequencer control store of the register execute unit.
`default_nettype none

package ure_pkg;

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;
  localparam int WORD_W   = 32;
  localparam int IMM_W    = 25;
  localparam logic [WORD_W-1:0] CHAR_LIMIT = 32'd255;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_SLOAD = 4'd1,
    OP_SSTORE = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_MAP   = 4'd8,
    OP_UNMAP = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LOADP = 4'd12,
    OP_LDI   = 4'd13,
    OP_WBACK = 4'd14
  } op_t;

  typedef enum logic [3:0] {
    K_NONE   = 4'd0,
    K_SLOAD  = 4'd1,
    K_SSTORE = 4'd2,
    K_MAP    = 4'd3,
    K_UNMAP  = 4'd4,
    K_OUT    = 4'd5,
    K_IN     = 4'd6,
    K_LOADP  = 4'd7,
    K_HALT   = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIV_ZERO = 3'd1,
    ST_OUT_RANGE = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  // sequencer step addresses
  typedef enum logic [2:0] {
    U_IDLE = 3'd0,
    U_RDA  = 3'd1,
    U_RDB  = 3'd2,
    U_RDC  = 3'd3,
    U_CAPC = 3'd4,
    U_EXEC = 3'd5,
    U_DIV  = 3'd6,
    U_WB   = 3'd7
  } uaddr_t;

  typedef enum logic [1:0] {
    RS_NONE = 2'd0,
    RS_A    = 2'd1,
    RS_B    = 2'd2,
    RS_C    = 2'd3
  } rsel_t;

  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_NO_VALID = 3'd1,
    CND_DIV      = 3'd2,
    CND_DIV_BUSY = 3'd3,
    CND_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    logic   take;       // request may be accepted
    rsel_t  rd_sel;     // register file read address
    rsel_t  cap_sel;    // operand latched from last read
    logic   exec;       // evaluate and register the result
    logic   div_start;
    logic   commit;     // write back and load the output register
    cond_t  cond;
    uaddr_t target;     // taken when cond holds
    uaddr_t next;
  } ctrl_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  function automatic ctrl_t ucode(input uaddr_t a);
    ctrl_t w;
    w = '{take: 1'b0, rd_sel: RS_NONE, cap_sel: RS_NONE, exec: 1'b0, div_start: 1'b0,
          commit: 1'b0, cond: CND_NEVER, target: U_IDLE, next: U_IDLE};
    unique case (a)
      U_IDLE: begin
        w.take = 1'b1; w.cond = CND_NO_VALID; w.target = U_IDLE; w.next = U_RDA;
      end
      U_RDA: begin
        w.rd_sel = RS_A; w.next = U_RDB;
      end
      U_RDB: begin
        w.rd_sel = RS_B; w.cap_sel = RS_A; w.next = U_RDC;
      end
      U_RDC: begin
        w.rd_sel = RS_C; w.cap_sel = RS_B; w.next = U_CAPC;
      end
      U_CAPC: begin
        w.cap_sel = RS_C; w.next = U_EXEC;
      end
      U_EXEC: begin
        w.exec = 1'b1; w.div_start = 1'b1;
        w.cond = CND_DIV; w.target = U_DIV; w.next = U_WB;
      end
      U_DIV: begin
        w.cond = CND_DIV_BUSY; w.target = U_DIV; w.next = U_WB;
      end
      U_WB: begin
        w.commit = 1'b1; w.cond = CND_OUT_BUSY; w.target = U_WB; w.next = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ure_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ure_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ure_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ure_div (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  ure_pkg::div_req_t     req,
  output logic                        busy,
  output logic [ure_pkg::WORD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(ure_pkg::WORD_W);

  logic [ure_pkg::WORD_W-1:0] rem;
  logic [ure_pkg::WORD_W-1:0] divisor;
  logic [CNT_W-1:0]           cnt;
  logic [ure_pkg::WORD_W:0]   shifted;
  logic [ure_pkg::WORD_W:0]   trial;
  logic                       fits;

  always_comb begin
    shifted = {rem, quotient[ure_pkg::WORD_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= '0;
      quotient <= req.dividend;
      divisor  <= req.divisor;
    end else if (busy) begin
      rem      <= fits ? trial[ure_pkg::WORD_W-1:0] : shifted[ure_pkg::WORD_W-1:0];
      quotient <= {quotient[ure_pkg::WORD_W-2:0], fits};
      cnt      <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(ure_pkg::WORD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/um_register_execute_unit.sv
// Top level: microcoded execute unit for the 32-bit universal machine.
// Sequence per request: the three operand reads through the single read port of the
//   register file, evaluation, the bit-serial divider iterations for a divide by a
//   non-zero register, then write-back, held while a waiting result is stalled.
// A new request is taken only after the previous one has been written back.
// Reset (rst, synchronous): sequencer to idle, register valid bits, counter,
//   halt flag and output valid cleared; no clearing pass.
`default_nettype none

module um_register_execute_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  func,
  input  wire  [2:0]  reg_a,
  input  wire  [2:0]  reg_b,
  input  wire  [2:0]  reg_c,
  input  wire  [24:0] immediate,
  input  wire  [31:0] return_value,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  request_kind,
  output logic [31:0] operand_a,
  output logic [31:0] operand_b,
  output logic [31:0] operand_c,
  output logic [31:0] next_pc,
  output logic [2:0]  status
);

  localparam int W = ure_pkg::WORD_W;
  localparam int IW = ure_pkg::IDX_W;

  ure_pkg::uaddr_t upc, upc_next;
  ure_pkg::ctrl_t  cw;

  // latched request
  ure_pkg::op_t                it_op;
  logic [IW-1:0]               it_a, it_b, it_c;
  logic [ure_pkg::IMM_W-1:0]   it_imm;
  logic [W-1:0]                it_ret;

  logic [W-1:0] va, vb, vc;
  logic [W-1:0] pc;
  logic         halted;
  logic [ure_pkg::NUM_REGS-1:0] reg_valid;
  logic         rd_valid;

  // register file port
  logic          rf_re;
  logic [IW-1:0] rf_raddr;
  logic [W-1:0]  rf_rdata;
  logic          rf_we;
  logic [W-1:0]  rf_wdata;
  logic [W-1:0]  rd_word;

  // evaluated result
  ure_pkg::kind_t   ex_kind, res_kind;
  ure_pkg::status_t ex_status, res_status;
  logic             ex_we, res_we;
  logic             ex_div, res_div;
  logic             ex_halt, res_halt;
  logic [W-1:0]     ex_data, res_data;
  logic [W-1:0]     ex_pc, res_pc;
  logic [W-1:0]     res_opa, res_opb, res_opc;
  logic             ex_ops;

  ure_pkg::div_req_t div_req;
  logic              div_busy;
  logic [W-1:0]      div_q;

  logic accept, out_busy, commit, cond_hit;

  assign cw       = ure_pkg::ucode(upc);
  assign in_stall = !cw.take;
  assign accept   = in_valid && cw.take;
  assign out_busy = out_valid && out_stall;
  assign commit   = cw.commit && !out_busy;

  always_comb begin
    unique case (cw.cond)
      ure_pkg::CND_NO_VALID: cond_hit = !in_valid;
      ure_pkg::CND_DIV:      cond_hit = ex_div;
      ure_pkg::CND_DIV_BUSY: cond_hit = div_busy;
      ure_pkg::CND_OUT_BUSY: cond_hit = out_busy;
      default:               cond_hit = 1'b0;
    endcase
    upc_next = cond_hit ? cw.target : cw.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ure_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_op  <= ure_pkg::op_t'(func);
      it_a   <= reg_a;
      it_b   <= reg_b;
      it_c   <= reg_c;
      it_imm <= immediate;
      it_ret <= return_value;
    end
  end

  // register file reads, one index per step
  always_comb begin
    rf_re = cw.rd_sel != ure_pkg::RS_NONE;
    unique case (cw.rd_sel)
      ure_pkg::RS_B: rf_raddr = it_b;
      ure_pkg::RS_C: rf_raddr = it_c;
      default:       rf_raddr = it_a;
    endcase
  end

  ure_ram #(
    .WIDTH(W),
    .DEPTH(ure_pkg::NUM_REGS)
  ) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (it_a),
    .wdata (rf_wdata),
    .re    (rf_re),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // never-written registers read as zero
  assign rd_word = rd_valid ? rf_rdata : '0;

  always_ff @(posedge clk) begin
    if (rf_re) begin
      rd_valid <= reg_valid[rf_raddr];
    end
    unique case (cw.cap_sel)
      ure_pkg::RS_A: va <= rd_word;
      ure_pkg::RS_B: vb <= rd_word;
      ure_pkg::RS_C: vc <= rd_word;
      default: ;
    endcase
  end

  always_comb begin
    ex_kind   = ure_pkg::K_NONE;
    ex_status = ure_pkg::ST_OK;
    ex_we     = 1'b0;
    ex_div    = 1'b0;
    ex_halt   = 1'b0;
    ex_data   = vb;
    ex_pc     = pc + W'(1);
    if (halted) begin
      ex_status = ure_pkg::ST_HALTED;
      ex_pc     = pc;
    end else begin
      unique case (it_op)
        ure_pkg::OP_CMOV:   ex_we = vc != '0;
        ure_pkg::OP_SLOAD:  ex_kind = ure_pkg::K_SLOAD;
        ure_pkg::OP_SSTORE: ex_kind = ure_pkg::K_SSTORE;
        ure_pkg::OP_ADD: begin
          ex_we = 1'b1; ex_data = vb + vc;
        end
        ure_pkg::OP_MUL: begin
          ex_we = 1'b1; ex_data = vb * vc;
        end
        ure_pkg::OP_DIV: begin
          if (vc == '0) begin
            ex_status = ure_pkg::ST_DIV_ZERO;
          end else begin
            ex_we = 1'b1; ex_div = 1'b1;
          end
        end
        ure_pkg::OP_NAND: begin
          ex_we = 1'b1; ex_data = ~(vb & vc);
        end
        ure_pkg::OP_HALT: begin
          ex_kind = ure_pkg::K_HALT; ex_status = ure_pkg::ST_HALTED; ex_halt = 1'b1;
        end
        ure_pkg::OP_MAP:   ex_kind = ure_pkg::K_MAP;
        ure_pkg::OP_UNMAP: ex_kind = ure_pkg::K_UNMAP;
        ure_pkg::OP_OUT: begin
          if (vc > ure_pkg::CHAR_LIMIT) begin
            ex_status = ure_pkg::ST_OUT_RANGE;
          end else begin
            ex_kind = ure_pkg::K_OUT;
          end
        end
        ure_pkg::OP_IN: ex_kind = ure_pkg::K_IN;
        ure_pkg::OP_LOADP: begin
          if (vb != '0) begin
            ex_kind = ure_pkg::K_LOADP;
          end
          ex_pc = vc;
        end
        ure_pkg::OP_LDI: begin
          ex_we = 1'b1; ex_data = W'(it_imm);
        end
        ure_pkg::OP_WBACK: begin
          ex_we = 1'b1; ex_data = it_ret; ex_pc = pc;
        end
        default: begin
          ex_status = ure_pkg::ST_BAD_OP; ex_halt = 1'b1;
        end
      endcase
    end
    ex_ops = ex_kind != ure_pkg::K_NONE && ex_kind != ure_pkg::K_HALT;
  end

  always_comb begin
    div_req.start    = cw.div_start && ex_div;
    div_req.dividend = vb;
    div_req.divisor  = vc;
  end

  ure_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cw.exec) begin
      res_kind   <= ex_kind;
      res_status <= ex_status;
      res_we     <= ex_we;
      res_div    <= ex_div;
      res_halt   <= ex_halt;
      res_data   <= ex_data;
      res_pc     <= ex_pc;
      res_opa    <= ex_ops ? va : '0;
      res_opb    <= ex_ops ? vb : '0;
      res_opc    <= ex_ops ? vc : '0;
    end
  end

  assign rf_we    = commit && res_we;
  assign rf_wdata = res_div ? div_q : res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      pc        <= '0;
      halted    <= 1'b0;
    end else if (commit) begin
      if (res_we) begin
        reg_valid[it_a] <= 1'b1;
      end
      pc     <= res_pc;
      halted <= halted || res_halt;
    end
  end

  // output register: a waiting result does not stop the next request being taken, but holds its write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      request_kind <= res_kind;
      operand_a    <= res_opa;
      operand_b    <= res_opb;
      operand_c    <= res_opc;
      next_pc      <= res_pc;
      status       <= res_status;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ure_checker.sv
// Port-level checks on the execute unit results, bound to the top level.
`default_nettype none

module ure_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_stall,
  input wire [3:0]  request_kind,
  input wire [31:0] operand_a,
  input wire [31:0] operand_b,
  input wire [31:0] operand_c,
  input wire [31:0] next_pc,
  input wire [2:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(request_kind))
    else $error("stalled result changed");

  a_quiet_ops: assert property (@(posedge clk) disable iff (rst)
    out_valid && (request_kind == ure_pkg::K_NONE || request_kind == ure_pkg::K_HALT)
      |-> operand_a == '0 && operand_b == '0 && operand_c == '0)
    else $error("operands set on a result with no request");

  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_kind == ure_pkg::K_HALT |-> status == ure_pkg::ST_HALTED)
    else $error("halt request without halted status");

  a_fault_no_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ure_pkg::ST_DIV_ZERO || status == ure_pkg::ST_OUT_RANGE
                  || status == ure_pkg::ST_BAD_OP)
      |-> request_kind == ure_pkg::K_NONE)
    else $error("request sent with a fault status");

endmodule

bind um_register_execute_unit ure_checker u_ure_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .request_kind (request_kind),
  .operand_a    (operand_a),
  .operand_b    (operand_b),
  .operand_c    (operand_c),
  .next_pc      (next_pc),
  .status       (status)
);

`default_nettype wire
